// File: sv/mptf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mptf_pkg;

  // Width of the threshold and release floor registers.
  localparam int REG_WIDTH = 15;

  localparam int TIME_WIDTH  = 32;
  localparam int INDEX_WIDTH = 16;
  localparam int COUNT_WIDTH = 16;

  // Entries in the result queue; two free slots are needed to take a beat.
  localparam int FIFO_DEPTH = 4;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOISY = 2'd1,
    ST_NONE  = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    REG_THRESHOLD     = 1'b0,
    REG_RELEASE_FLOOR = 1'b1
  } reg_index_t;

  // Results written into the queue by one input beat.
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

endpackage

`default_nettype wire

// File: sv/mptf_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module mptf_fifo
  import mptf_pkg::*;
#(
  parameter int WIDTH = 84
) (
  input  logic             clk,
  input  logic             rst,
  input  push_t            push,
  input  logic [WIDTH-1:0] din0,
  input  logic [WIDTH-1:0] din1,
  output logic             room,
  output logic             valid,
  input  logic             ready,
  output logic [WIDTH-1:0] dout
);

  localparam int PW   = $clog2(FIFO_DEPTH);
  localparam int CNTW = $clog2(FIFO_DEPTH + 1);

  logic [WIDTH-1:0] mem [FIFO_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;
  logic [CNTW-1:0]  count_next;
  logic [1:0]       npush;
  logic             pop;

  assign valid = (count != '0);
  assign room  = (count <= CNTW'(FIFO_DEPTH - 2));
  assign pop   = valid && ready;
  assign dout  = mem[rd_ptr];

  always_comb begin
    npush      = {1'b0, push.first} + {1'b0, push.second};
    count_next = count + CNTW'(npush) - CNTW'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      count  <= count_next;
      wr_ptr <= wr_ptr + PW'(npush);
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
    end
  end

  // The first result of a beat always lands at the write pointer.
  always_ff @(posedge clk) begin
    if (push.first) begin
      mem[wr_ptr] <= din0;
    end
    if (push.second) begin
      mem[wr_ptr + PW'(1)] <= din1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(FIFO_DEPTH))
    else $error("result queue count exceeds depth");

  a_push_order: assert property (@(posedge clk) disable iff (rst)
    push.second |-> push.first)
    else $error("second result pushed without a first");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push.first |-> room)
    else $error("result pushed without two free slots");

endmodule

`default_nettype wire

// File: sv/multi_peak_threshold_finder.sv
`timescale 1ns / 1ps
`default_nettype none
// Results of an accepted beat are written into the result queue and presented from it on the master side.
// Throughput: one input beat per cycle while the queue has two free slots; per-sample compare and update is one stage.
// A record-ending beat that also closes a peak yields two result beats; the four-entry
// result queue drains one per cycle while m_tready is high; s_tready needs two free slots.
// Reset (rst, synchronous, active high) clears detector state, empties the queue
// and loads threshold = 1000 and release_floor = 500.

module multi_peak_threshold_finder
  import mptf_pkg::*;
#(
  parameter int SAMPLE_WIDTH       = 16,
  parameter int MAX_RECORD_SAMPLES = 65536
) (
  input  logic clk,
  input  logic rst,

  input  logic                 wr_en,
  input  logic                 wr_index,
  input  logic [REG_WIDTH-1:0] wr_data,

  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  // sample, sample_time
  input  logic [((SAMPLE_WIDTH+32+7)/8)*8-1:0]     s_tdata,
  input  logic                                     s_tlast,

  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  // peak_value, peak_time, peak_index, peak_count, status
  output logic [((SAMPLE_WIDTH+66+7)/8)*8-1:0]     m_tdata,
  // is_summary
  output logic                                     m_tuser,
  output logic                                     m_tlast
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int OUT_TW = ((SW + 66 + 7) / 8) * 8;
  localparam int XW     = (SW > 16 ? SW : 16) + 1;
  localparam int CW     = $clog2(MAX_RECORD_SAMPLES);
  localparam int RES_W  = SW + TIME_WIDTH + INDEX_WIDTH + COUNT_WIDTH + 2 + 1 + 1;

  logic [REG_WIDTH-1:0] threshold;
  logic [REG_WIDTH-1:0] release_floor;

  logic                   armed;
  logic signed [SW-1:0]   held_max;
  logic [INDEX_WIDTH-1:0] held_index;
  logic [TIME_WIDTH-1:0]  held_time;
  logic [CW-1:0]          sample_counter;
  logic                   ever_armed;
  logic [COUNT_WIDTH-1:0] found_count;

  logic                   armed_next;
  logic signed [SW-1:0]   held_max_next;
  logic [INDEX_WIDTH-1:0] held_index_next;
  logic [TIME_WIDTH-1:0]  held_time_next;
  logic [CW-1:0]          sample_counter_next;
  logic                   ever_armed_next;
  logic [COUNT_WIDTH-1:0] found_count_next;

  logic                   accept;
  logic signed [SW-1:0]   smp;
  logic [TIME_WIDTH-1:0]  smp_time;
  logic signed [XW-1:0]   smp_x;
  logic signed [XW-1:0]   mag_x;
  logic signed [XW-1:0]   thr_x;
  logic signed [XW-1:0]   floor_x;
  logic                   raise;
  logic                   at_thr;
  logic                   in_release;
  logic                   emit_peak;
  status_t                status;

  logic [RES_W-1:0] peak_res;
  logic [RES_W-1:0] sum_res;
  logic [RES_W-1:0] din0;
  logic [RES_W-1:0] q_dout;
  push_t            push;
  logic             room;

  assign s_tready = room;
  assign accept   = s_tvalid && s_tready;
  assign smp      = s_tdata[SW-1:0];
  assign smp_time = s_tdata[SW+TIME_WIDTH-1:SW];

  always_comb begin
    smp_x      = XW'(smp);
    mag_x      = (smp_x < 0) ? -smp_x : smp_x;
    thr_x      = $signed({{(XW - REG_WIDTH){1'b0}}, threshold});
    floor_x    = $signed({{(XW - REG_WIDTH){1'b0}}, release_floor});
    raise      = smp > held_max;
    at_thr     = smp_x >= thr_x;
    in_release = !at_thr && (mag_x >= floor_x);
  end

  always_comb begin
    armed_next      = armed;
    held_max_next   = held_max;
    held_index_next = held_index;
    held_time_next  = held_time;
    ever_armed_next = ever_armed;
    emit_peak       = 1'b0;

    if (!armed) begin
      if (at_thr && raise) begin
        held_max_next   = smp;
        held_index_next = INDEX_WIDTH'(sample_counter);
        held_time_next  = smp_time;
        armed_next      = 1'b1;
        ever_armed_next = 1'b1;
      end
    end else if (raise) begin
      held_max_next   = smp;
      held_index_next = INDEX_WIDTH'(sample_counter);
      held_time_next  = smp_time;
    end else if (in_release) begin
      emit_peak       = 1'b1;
      held_max_next   = smp;
      held_index_next = INDEX_WIDTH'(sample_counter);
      held_time_next  = smp_time;
      armed_next      = 1'b0;
    end else if (s_tlast) begin
      emit_peak = 1'b1;
    end

    if (sample_counter == CW'(MAX_RECORD_SAMPLES - 1)) begin
      sample_counter_next = '0;
    end else begin
      sample_counter_next = sample_counter + CW'(1);
    end

    // The count saturates rather than wrapping on a very busy record.
    if (emit_peak && (found_count != '1)) begin
      found_count_next = found_count + COUNT_WIDTH'(1);
    end else begin
      found_count_next = found_count;
    end

    if (!ever_armed_next) begin
      status = ST_NOISY;
    end else if (found_count_next == '0) begin
      status = ST_NONE;
    end else begin
      status = ST_OK;
    end
  end

  // Result word, lowest field first: value, time, index, count, status,
  // is_summary, run_last.
  always_comb begin
    peak_res = {1'b0, 1'b0, 2'b00, {COUNT_WIDTH{1'b0}}, held_index, held_time, held_max};
    sum_res  = {1'b1, 1'b1, status, found_count_next, {INDEX_WIDTH{1'b0}},
                {TIME_WIDTH{1'b0}}, {SW{1'b0}}};
    din0     = emit_peak ? peak_res : sum_res;
    push.first  = accept && (emit_peak || s_tlast);
    push.second = accept && emit_peak && s_tlast;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold     <= REG_WIDTH'(1000);
      release_floor <= REG_WIDTH'(500);
    end else if (wr_en) begin
      unique case (reg_index_t'(wr_index))
        REG_THRESHOLD:     threshold     <= wr_data;
        REG_RELEASE_FLOOR: release_floor <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && s_tlast)) begin
      armed          <= 1'b0;
      held_max       <= '0;
      held_index     <= '0;
      held_time      <= '0;
      sample_counter <= '0;
      ever_armed     <= 1'b0;
      found_count    <= '0;
    end else if (accept) begin
      armed          <= armed_next;
      held_max       <= held_max_next;
      held_index     <= held_index_next;
      held_time      <= held_time_next;
      sample_counter <= sample_counter_next;
      ever_armed     <= ever_armed_next;
      found_count    <= found_count_next;
    end
  end

  mptf_fifo #(
    .WIDTH (RES_W)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din0  (din0),
    .din1  (sum_res),
    .room  (room),
    .valid (m_tvalid),
    .ready (m_tready),
    .dout  (q_dout)
  );

  assign m_tdata = OUT_TW'(q_dout[RES_W-3:0]);
  assign m_tuser = q_dout[RES_W-2];
  assign m_tlast = q_dout[RES_W-1];

  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tlast)
    else $error("summary beat without tlast");

  a_record_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tlast) |=> (!armed && !ever_armed && sample_counter == '0
                             && found_count == '0))
    else $error("state not cleared after record end");

  a_armed_ever: assert property (@(posedge clk) disable iff (rst)
    armed |-> ever_armed)
    else $error("armed without ever_armed");

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import mptf_pkg::*;

  localparam int S_BITS = 48;
  localparam int M_BITS = 88;

  typedef struct packed {
    logic signed [15:0] value;
    logic [31:0]        stamp;
    logic [15:0]        index;
    logic [15:0]        count;
    status_t            status;
    logic               summary;
    logic               rec_last;
  } peak_beat_t;

  typedef struct {
    int          smp;
    logic [31:0] stamp;
    bit          last;
    bit          typed;
    int          cnt;
    status_t     st;
  } dir_row_t;

  // Sample classes used to build pulse-shaped records.
  typedef enum int {QUIET, HIGH, RELEASE, ANY} sample_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 wr_en    = 1'b0;
  logic                 wr_index = 1'b0;
  logic [REG_WIDTH-1:0] wr_data  = '0;

  logic              s_tvalid = 1'b0;
  logic              s_tready;
  // sample, sample_time
  logic [S_BITS-1:0] s_tdata  = '0;
  logic              s_tlast  = 1'b0;

  logic              m_tvalid;
  logic              m_tready = 1'b0;
  // peak_value, peak_time, peak_index, peak_count, status
  logic [M_BITS-1:0] m_tdata;
  // is_summary
  logic              m_tuser;
  logic              m_tlast;

  multi_peak_threshold_finder i_dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // Detector state mirrored by the checker.
  logic [REG_WIDTH-1:0] level_thr   = 15'd1000;
  logic [REG_WIDTH-1:0] level_floor = 15'd500;
  logic                 armed       = 1'b0;
  logic signed [15:0]   held_max    = '0;
  logic [15:0]          held_index  = '0;
  logic [31:0]          held_stamp  = '0;
  logic [15:0]          sample_idx  = '0;
  logic                 ever_armed  = 1'b0;
  logic [15:0]          found_count = '0;

  peak_beat_t peak_results_due[$];

  int  mismatches   = 0;
  int  samples_sent = 0;
  int  records_sent = 0;
  int  peaks_seen   = 0;
  int  summaries    = 0;
  int  settings     = 0;
  bit  bursty       = 1'b1;

  function automatic void emit_peak();
    peak_beat_t b;
    b        = '0;
    b.value  = held_max;
    b.stamp  = held_stamp;
    b.index  = held_index;
    peak_results_due.insert(peak_results_due.size(), b);
    if (found_count != 16'hFFFF) found_count++;
  endfunction

  function automatic void hold_sample(input logic signed [15:0] smp, input logic [31:0] stamp);
    held_max   = smp;
    held_index = sample_idx;
    held_stamp = stamp;
  endfunction

  function automatic void detect_peaks(input logic signed [15:0] smp, input logic [31:0] stamp,
                                       input logic last);
    peak_beat_t b;
    int s;
    int mag;
    s   = smp;
    mag = (s < 0) ? -s : s;
    if (!armed) begin
      if (s >= int'(level_thr) && s > int'(held_max)) begin
        hold_sample(smp, stamp);
        armed      = 1'b1;
        ever_armed = 1'b1;
      end
    end else if (s > int'(held_max)) begin
      hold_sample(smp, stamp);
    end else if (s < int'(level_thr) && mag >= int'(level_floor)) begin
      emit_peak();
      hold_sample(smp, stamp);
      armed = 1'b0;
    end else if (last) begin
      emit_peak();
    end
    sample_idx++;
    if (last) begin
      b          = '0;
      b.count    = found_count;
      b.status   = !ever_armed ? ST_NOISY : (found_count == 0) ? ST_NONE : ST_OK;
      b.summary  = 1'b1;
      b.rec_last = 1'b1;
      peak_results_due.insert(peak_results_due.size(), b);
      armed       = 1'b0;
      held_max    = '0;
      held_index  = '0;
      held_stamp  = '0;
      sample_idx  = '0;
      ever_armed  = 1'b0;
      found_count = '0;
    end
  endfunction

  // Called at a rising edge; returns at the edge where the beat is taken.
  task automatic send_sample(input logic signed [15:0] smp, input logic [31:0] stamp,
                             input logic last);
    if (bursty && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {stamp, smp};
    s_tlast  <= last;
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
    detect_peaks(smp, stamp, last);
    samples_sent++;
    if (last) records_sent++;
  endtask

  task automatic load_levels(input int thr, input int floor_lvl);
    s_tvalid <= 1'b0;
    while (peak_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= REG_THRESHOLD;
    wr_data  <= thr[REG_WIDTH-1:0];
    @(posedge clk);
    level_thr = thr[REG_WIDTH-1:0];
    wr_index <= REG_RELEASE_FLOOR;
    wr_data  <= floor_lvl[REG_WIDTH-1:0];
    @(posedge clk);
    level_floor = floor_lvl[REG_WIDTH-1:0];
    wr_en <= 1'b0;
    settings++;
  endtask

  function automatic logic [15:0] pick_sample(input sample_kind_t kind);
    int thr;
    int fl;
    int v;
    thr = level_thr;
    fl  = level_floor;
    case (kind)
      QUIET: begin
        v = (fl > 0) ? int'($urandom_range(0, 2 * (fl - 1))) - (fl - 1) : 0;
      end
      HIGH: begin
        v = $urandom_range(thr, 32767);
      end
      RELEASE: begin
        if (fl < thr && $urandom_range(0, 1) == 0) v = $urandom_range(fl, thr - 1);
        else v = -int'($urandom_range((fl == 0) ? 1 : fl, 32768));
      end
      default: begin
        v = $urandom();
      end
    endcase
    return v[15:0];
  endfunction

  // Builds one record out of runs of similar samples, so pulses rise, hold and fall.
  task automatic send_record(input int len, inout logic [31:0] stamp);
    sample_kind_t kind;
    int run;
    kind = QUIET;
    run  = 0;
    for (int i = 0; i < len; i++) begin
      if (run == 0) begin
        case ($urandom_range(0, 99)) inside
          [0:29]:  kind = QUIET;
          [30:64]: kind = HIGH;
          [65:84]: kind = RELEASE;
          default: kind = ANY;
        endcase
        run = $urandom_range(1, 4);
      end
      run--;
      if ($urandom_range(0, 19) == 0) stamp = $urandom();
      else stamp += $urandom_range(1, 1000);
      send_sample(pick_sample(kind), stamp, i == len - 1);
    end
  endtask

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(negedge clk) begin : check_results
    peak_beat_t got;
    peak_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.value    = m_tdata[15:0];
      got.stamp    = m_tdata[47:16];
      got.index    = m_tdata[63:48];
      got.count    = m_tdata[79:64];
      got.status   = status_t'(m_tdata[81:80]);
      got.summary  = m_tuser;
      got.rec_last = m_tlast;
      if (got.summary) summaries++;
      else peaks_seen++;
      if (peak_results_due.size() == 0) begin
        $display("%0t ns: unexpected result beat, expected none, got %h", $time, m_tdata);
        mismatches++;
      end else begin
        want = peak_results_due.pop_front();
        compare_field("peak_value", want.value, got.value);
        compare_field("peak_time", want.stamp, got.stamp);
        compare_field("peak_index", want.index, got.index);
        compare_field("peak_count", want.count, got.count);
        compare_field("status", want.status, got.status);
        compare_field("is_summary", want.summary, got.summary);
        compare_field("run_last", want.rec_last, got.rec_last);
      end
    end
  end

  // Output stalls come in bursts while bursty is set.
  initial begin : drive_ready
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (bursty && stall_left == 0 && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 9);
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    #10_000_000;
    $display("tb: errors");
    $finish;
  end

  initial begin : stimulus
    dir_row_t dir_rows[19];
    int levels[8][2];
    logic [31:0] stamp;
    int phase_items;
    int thr;

    // Default levels 1000 / 500 apply to the whole table.
    dir_rows = '{
      // lone quiet sample: never armed
      '{0,       32'h0000_0000, 1, 1, 0, ST_NOISY},
      // arm exactly at threshold, grow, then release on the most negative sample
      '{1000,    32'h0000_0010, 0, 0, 0, ST_OK},
      '{2000,    32'h0000_0020, 0, 0, 0, ST_OK},
      '{1500,    32'h0000_0030, 0, 0, 0, ST_OK},
      '{-32768,  32'h0000_0040, 0, 0, 0, ST_OK},
      '{1000,    32'h0000_0050, 0, 0, 0, ST_OK},
      '{0,       32'h0000_0060, 0, 0, 0, ST_OK},
      // last sample raises the maximum: no peak for the second pulse
      '{32767,   32'h0000_0070, 1, 1, 1, ST_OK},
      // arming on the last sample
      '{500,     32'h8000_0000, 0, 0, 0, ST_OK},
      '{1200,    32'h8000_0001, 1, 1, 0, ST_NONE},
      // still armed at record end: peak and summary from one beat
      '{5000,    32'h1234_5678, 0, 0, 0, ST_OK},
      '{3000,    32'h1234_5679, 1, 1, 1, ST_OK},
      // release on the last sample: two beats as well
      '{1500,    32'h7FFF_FFFE, 0, 0, 0, ST_OK},
      '{-600,    32'h7FFF_FFFF, 1, 1, 1, ST_OK},
      // two pulses, the second closed by the record end
      '{-32768,  32'hFFFF_FFFB, 0, 0, 0, ST_OK},
      '{32767,   32'hFFFF_FFFC, 0, 0, 0, ST_OK},
      '{-1000,   32'hFFFF_FFFD, 0, 0, 0, ST_OK},
      '{32767,   32'hFFFF_FFFE, 0, 0, 0, ST_OK},
      '{499,     32'hFFFF_FFFF, 1, 1, 2, ST_OK}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_sample(dir_rows[i].smp[15:0], dir_rows[i].stamp, dir_rows[i].last);
      if (dir_rows[i].typed) begin
        peak_results_due[peak_results_due.size() - 1].count  = dir_rows[i].cnt[15:0];
        peak_results_due[peak_results_due.size() - 1].status = dir_rows[i].st;
      end
    end

    levels[0] = '{0, 0};
    levels[1] = '{32767, 32767};
    levels[2] = '{32767, 0};
    levels[3] = '{0, 32767};
    for (int p = 4; p < 8; p++) begin
      thr = $urandom_range(1, 32767);
      levels[p] = '{thr, thr - thr / int'($urandom_range(1, 8))};
    end

    stamp = $urandom();
    for (int p = 0; p < 8; p++) begin
      load_levels(levels[p][0], levels[p][1]);
      bursty = ($urandom_range(0, 3) != 0);
      phase_items = 0;
      while (phase_items < 130) begin
        thr = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 30);
        send_record(thr, stamp);
        phase_items += thr;
      end
    end

    // The last stretch runs with no idling on either side.
    load_levels(12000, 3000);
    bursty = 1'b0;
    phase_items = 0;
    while (phase_items < 130) begin
      thr = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 30);
      send_record(thr, stamp);
      phase_items += thr;
    end
    s_tvalid <= 1'b0;

    while (peak_results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("tb: %0d samples in %0d records under %0d level settings", samples_sent,
             records_sent, settings + 1);
    $display("tb: %0d peak beats and %0d summaries checked", peaks_seen, summaries);
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// File: multi_peak_threshold_finder.f
sv/mptf_pkg.sv
sv/mptf_fifo.sv
sv/multi_peak_threshold_finder.sv
tb/tb.sv
